// ===== src/anti_replay_window_check_macros.svh =====
// ---------------------------------------------------------------------------
// anti replay window check assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef ANTI_REPLAY_WINDOW_CHECK_MACROS_SVH
`define ANTI_REPLAY_WINDOW_CHECK_MACROS_SVH

// same-cycle implication
`define ARWC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/arwc_pkg.sv =====
// ---------------------------------------------------------------------------
// arwc_pkg
// shared types and constants for the anti replay window checker
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package arwc_pkg;

  localparam int SOURCES     = 256;
  localparam int WINDOW_BITS = 64;

  localparam int SRC_W     = 8;
  localparam int NONCE_W   = 64;
  localparam int SRC_IDX_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int SH_W      = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;

  typedef enum logic [1:0] {
    VERDICT_OK    = 2'd0,
    VERDICT_OLD   = 2'd1,
    VERDICT_DUP   = 2'd2,
    VERDICT_RANGE = 2'd3
  } arwc_verdict_t;

  typedef struct packed {
    logic [SRC_W-1:0]   source_id;
    logic [NONCE_W-1:0] nonce;
  } arwc_in_t;

  typedef struct packed {
    logic          accept;
    arwc_verdict_t verdict;
  } arwc_out_t;

  // compare results handed from the read stage to the update stage
  typedef struct packed {
    logic            range_bad;
    logic            armed;
    logic            greater;
    logic            far;
    logic [SH_W-1:0] shift;
  } arwc_chk_t;

endpackage

// ===== src/arwc_judge.sv =====
// ---------------------------------------------------------------------------
// arwc_judge
// window update and verdict from registered compare results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module arwc_judge (
  input  arwc_pkg::arwc_chk_t                   chk,
  input  logic [arwc_pkg::WINDOW_BITS-1:0]      win_rd,
  output logic [arwc_pkg::WINDOW_BITS-1:0]      win_new,
  output logic                                  we,
  output arwc_pkg::arwc_verdict_t               verdict
);
  import arwc_pkg::*;

  logic [WINDOW_BITS-1:0] one_w;
  logic [WINDOW_BITS-1:0] bit_w;

  assign one_w = WINDOW_BITS'(1);
  assign bit_w = one_w << chk.shift;

  always_comb begin
    win_new = win_rd;
    we      = 1'b0;
    verdict = VERDICT_OK;
    if (chk.range_bad) begin
      verdict = VERDICT_RANGE;
    end else if (!chk.armed) begin
      // first nonce from this source
      win_new = one_w;
      we      = 1'b1;
    end else if (chk.greater) begin
      // slide up, drop everything on a long jump
      if (chk.far) begin
        win_new = one_w;
      end else begin
        win_new = (win_rd << chk.shift) | one_w;
      end
      we = 1'b1;
    end else if (chk.far) begin
      verdict = VERDICT_OLD;
    end else if ((win_rd & bit_w) != '0) begin
      verdict = VERDICT_DUP;
    end else begin
      win_new = win_rd | bit_w;
      we      = 1'b1;
    end
  end

endmodule

// ===== src/anti_replay_window_check.sv =====
// ---------------------------------------------------------------------------
// anti_replay_window_check
// per-source sliding window replay check over a 64-bit nonce
// ---------------------------------------------------------------------------
// A request (source_id, nonce) is taken when start is high and busy is low.
// Every request yields exactly one result, shown on out_res for a single
// cycle with out_strobe high; the receiver cannot stall it, so it must
// sample at that edge. A request first has the per-source memories read at
// the accept edge; the ST_RD state then does the 64-bit nonce compares, and
// ST_EX updates the window and writes it back; the result is on the ports
// the cycle after that write, while busy is already low again. A new request
// is taken only once this read, compare, write loop through the single-port
// memories is done, since busy stays high until then. The armed flags reset
// to zero at once, so no clearing pass is needed after reset; verdict codes
// are 0 accepted, 1 too old, 2 duplicate, 3 source out of range, and accept
// is high for code 0 only.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module anti_replay_window_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  arwc_pkg::arwc_in_t  in_req,
  output logic                out_strobe,
  output arwc_pkg::arwc_out_t out_res
);
  import arwc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_EX   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // per-source storage: highest nonce and seen window live in memories,
  // the armed flags in flops so reset clears them all directly
  logic [NONCE_W-1:0]     hi_mem  [SOURCES];
  logic [WINDOW_BITS-1:0] win_mem [SOURCES];
  logic [SOURCES-1:0]     armed_r;

  // request and read data
  arwc_in_t               req_r;
  logic [NONCE_W-1:0]     hi_rd_r;
  logic [WINDOW_BITS-1:0] win_rd_r;
  logic                   armed_rd_r;
  arwc_chk_t              chk_r, chk_nxt;

  logic                   in_fire;
  logic [SRC_IDX_W-1:0]   in_idx;
  logic [SRC_IDX_W-1:0]   req_idx;

  // compare stage
  logic [NONCE_W:0]       up_diff;
  logic [NONCE_W-1:0]     dn_diff;
  logic                   greater;

  // update stage
  logic [WINDOW_BITS-1:0] win_new;
  logic                   judge_we;
  arwc_verdict_t          verdict;
  logic                   mem_we;

  logic                   out_strobe_r;
  arwc_out_t              out_res_r;

  assign busy    = (state_r != ST_IDLE);
  assign in_fire = start && !busy;
  assign in_idx  = in_req.source_id[SRC_IDX_W-1:0];
  assign req_idx = req_r.source_id[SRC_IDX_W-1:0];

  // control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_EX;
      ST_EX:   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == ST_EX);
    end
  end

  function automatic logic greater_or_arm(arwc_chk_t c);
    return c.greater || !c.armed;
  endfunction

  // memory read at accept, write back at the end of the update stage;
  // busy keeps the next read behind this write, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hi_rd_r  <= hi_mem[in_idx];
      win_rd_r <= win_mem[in_idx];
    end
    if (mem_we) begin
      hi_mem[req_idx]  <= greater_or_arm(chk_r) ? req_r.nonce : hi_rd_r;
      win_mem[req_idx] <= win_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= '0;
    end else if (mem_we) begin
      armed_r[req_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r      <= in_req;
      armed_rd_r <= armed_r[in_idx];
    end
  end

  // compare stage: both differences in parallel, only the low bits of the
  // chosen one survive as the shift amount
  assign up_diff = {1'b0, req_r.nonce} - {1'b0, hi_rd_r};
  assign dn_diff = hi_rd_r - req_r.nonce;
  assign greater = !up_diff[NONCE_W] && (up_diff[NONCE_W-1:0] != '0);

  always_comb begin
    chk_nxt.range_bad = ({1'b0, req_r.source_id} >= (SRC_W + 1)'(SOURCES));
    chk_nxt.armed     = armed_rd_r;
    chk_nxt.greater   = greater;
    if (greater) begin
      chk_nxt.far   = (up_diff[NONCE_W-1:0] >= NONCE_W'(WINDOW_BITS));
      chk_nxt.shift = up_diff[SH_W-1:0];
    end else begin
      chk_nxt.far   = (dn_diff >= NONCE_W'(WINDOW_BITS));
      chk_nxt.shift = dn_diff[SH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      chk_r <= chk_nxt;
    end
  end

  // update stage
  arwc_judge u_judge (
    .chk     (chk_r),
    .win_rd  (win_rd_r),
    .win_new (win_new),
    .we      (judge_we),
    .verdict (verdict)
  );

  assign mem_we = (state_r == ST_EX) && judge_we;

  always_ff @(posedge clk) begin
    if (state_r == ST_EX) begin
      out_res_r.accept  <= (verdict == VERDICT_OK);
      out_res_r.verdict <= verdict;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  // checks
  `include "anti_replay_window_check_macros.svh"

  `ARWC_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_r), "state not one-hot")
  `ARWC_ASSERT_NEXT(a_accept_reads, in_fire, state_r == ST_RD, "accept did not start read")
  `ARWC_ASSERT_NEXT(a_rd_to_ex, state_r == ST_RD, state_r == ST_EX, "compare stage skipped")
  `ARWC_ASSERT_NOW(a_strobe_after_ex, out_strobe, $past(state_r) == ST_EX, "stray result strobe")
  `ARWC_ASSERT_NOW(a_accept_code, out_strobe, out_res.accept == (out_res.verdict == VERDICT_OK), "accept and verdict disagree")

endmodule
